// ===== design/vna_pkg.sv =====
// Package for the vertex normal accumulator: request codes, payload types, states, defaults.
`timescale 1ns / 1ps
package vna_pkg;

	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_SUM_WIDTH    = 48;
	localparam int IDX_W            = 10;
	localparam int POS_W            = 16;
	localparam int EDGE_W           = 17;
	localparam int FACE_W           = 35;
	localparam int MUL_W            = 33;
	localparam int NORM_W           = 30;
	localparam int ROOT_STEP_W      = 64;
	localparam int DIV_W            = 46;
	localparam int QUO_W            = 15;

	localparam logic [1:0] REQ_WRITE    = 2'd0;
	localparam logic [1:0] REQ_TRIANGLE = 2'd1;
	localparam logic [1:0] REQ_READ     = 2'd2;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]        vertex_index;
		logic signed [POS_W-1:0] normal_x;
		logic signed [POS_W-1:0] normal_y;
		logic signed [POS_W-1:0] normal_z;
		logic                    degenerate;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POS_WR,
		S_TRI_RD,
		S_EDGE,
		S_CROSS,
		S_ACC_RD,
		S_ACC_WR,
		S_SUM_RD,
		S_SUM_LD,
		S_NORM,
		S_SQ,
		S_ROOT,
		S_DIV,
		S_DONE
	} state_t;

endpackage

// ===== design/vertex_normal_accumulator.sv =====
// Top level of the vertex normal accumulator: sequencer, shared multiplier, root and divider.
// Usage: one request channel (req_valid, req_stall, req_data) and one response
// channel (rsp_valid, rsp_stall, rsp_data), each moving a request when valid is
// high and stall is low. req_stall is high whenever the sequencer is busy; one
// request is worked on at a time.
// A write request is taken, then the position RAM is written and the vertex's
// sums are cleared. A triangle request runs through position reads, an edge
// step, the cross product through the shared multiplier, and a saturating
// read-modify-write of the sum RAM for each corner. A read request runs through
// sum read and load, normalising shifts of one bit each (up to 29 shifts), the
// squares through the multiplier, the bit-serial square root, restoring
// division per component and a final state; its response then sits in the output
// register. An out-of-range read goes from the sum read straight to the final
// state, a zero read from the sum load.
// Reset clears the sequencer and the output valid; RAM contents are not
// cleared, a vertex must be written before it is used. While the receiver
// stalls, the response is held and the sequencer waits in its final state
// before taking the next request.
`timescale 1ns / 1ps
module vertex_normal_accumulator #(
	parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
	parameter int SUM_WIDTH    = vna_pkg::DEF_SUM_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  vna_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vna_pkg::rsp_t rsp_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int SW = SUM_WIDTH;

	vna_pkg::state_t state_q, state_d;
	vna_pkg::req_t   req_q;

	logic [5:0] cnt_q;
	logic [1:0] cs_q;

	logic                 pos_we;
	logic [AW-1:0]        pos_raddr;
	logic [3*vna_pkg::POS_W-1:0] pos_rdata;
	logic                 sum_we;
	logic [AW-1:0]        sum_waddr, sum_raddr;
	logic [3*SW-1:0]      sum_wdata, sum_rdata, sum_acc;

	logic [3*vna_pkg::POS_W-1:0] p_q [3];
	logic signed [vna_pkg::EDGE_W-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [vna_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [2*vna_pkg::MUL_W-1:0] prod_q;
	logic signed [vna_pkg::FACE_W-1:0] nx_q, ny_q, nz_q;

	logic [SW-1:0] mx_q, my_q, mz_q, m_max;
	logic          negx_q, negy_q, negz_q, deg_q;
	logic [63:0]   sumsq_q, rem_q, root_q, bit_q, root_try;
	logic [vna_pkg::DIV_W-1:0] drem_q, dd_q, div_num;
	logic [vna_pkg::QUO_W-1:0] quo_q, qx_q, qy_q, qz_q;
	logic [vna_pkg::NORM_W-1:0] div_mag;

	logic          rsp_valid_q;
	vna_pkg::rsp_t rsp_q;

	logic req_take, a_ok, tri_ok, sums_zero, norm_ok;
	logic [vna_pkg::IDX_W-1:0] corner_rd, corner_acc;

	function automatic logic [AW-1:0] to_addr(input logic [vna_pkg::IDX_W-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[AW-1:0];
	endfunction

	function automatic logic in_range(input logic [vna_pkg::IDX_W-1:0] idx);
		return 32'(idx) < 32'(MAX_VERTICES);
	endfunction

	function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
		return v[SW-1] ? (SW'(0) - v) : v;
	endfunction

	// Memories
	vna_ram #(.WIDTH(3 * vna_pkg::POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (to_addr(req_q.corner_a)),
		.wdata ({req_q.pos_z, req_q.pos_y, req_q.pos_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	vna_ram #(.WIDTH(3 * SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	assign req_stall = (state_q != vna_pkg::S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign a_ok      = in_range(req_q.corner_a);
	assign tri_ok    = a_ok && in_range(req_q.corner_b) && in_range(req_q.corner_c);
	assign sums_zero = (sum_rdata == '0);

	// Pick corners for position reads and accumulator updates
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    corner_rd = req_q.corner_a;
			2'd1:    corner_rd = req_q.corner_b;
			default: corner_rd = req_q.corner_c;
		endcase
		case (cs_q)
			2'd0:    corner_acc = req_q.corner_a;
			2'd1:    corner_acc = req_q.corner_b;
			default: corner_acc = req_q.corner_c;
		endcase
	end

	// Saturating add of the face normal to each lane of the sums
	always_comb begin
		logic signed [SW:0] s;
		logic signed [vna_pkg::FACE_W-1:0] n;
		sum_acc = '0;
		for (int l = 0; l < 3; l++) begin
			n = (l == 0) ? nx_q : ((l == 1) ? ny_q : nz_q);
			s = (SW+1)'($signed(sum_rdata[l*SW +: SW])) + (SW+1)'(n);
			if (s[SW] != s[SW-1]) begin
				sum_acc[l*SW +: SW] = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			end else begin
				sum_acc[l*SW +: SW] = s[SW-1:0];
			end
		end
	end

	// Largest magnitude and normalising window
	always_comb begin
		m_max = (mx_q > my_q) ? mx_q : my_q;
		if (mz_q > m_max) begin
			m_max = mz_q;
		end
		norm_ok = (m_max < (SW'(1) << 30)) && (m_max >= (SW'(1) << 29));
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == vna_pkg::S_CROSS) begin
			case (cnt_q)
				6'd0: begin mul_a = vna_pkg::MUL_W'(e1y_q); mul_b = vna_pkg::MUL_W'(e2z_q); end
				6'd1: begin mul_a = vna_pkg::MUL_W'(e1z_q); mul_b = vna_pkg::MUL_W'(e2y_q); end
				6'd2: begin mul_a = vna_pkg::MUL_W'(e1z_q); mul_b = vna_pkg::MUL_W'(e2x_q); end
				6'd3: begin mul_a = vna_pkg::MUL_W'(e1x_q); mul_b = vna_pkg::MUL_W'(e2z_q); end
				6'd4: begin mul_a = vna_pkg::MUL_W'(e1x_q); mul_b = vna_pkg::MUL_W'(e2y_q); end
				default: begin mul_a = vna_pkg::MUL_W'(e1y_q); mul_b = vna_pkg::MUL_W'(e2x_q); end
			endcase
		end else begin
			case (cnt_q)
				6'd0: begin
					mul_a = $signed({3'b000, mx_q[vna_pkg::NORM_W-1:0]});
					mul_b = mul_a;
				end
				6'd1: begin
					mul_a = $signed({3'b000, my_q[vna_pkg::NORM_W-1:0]});
					mul_b = mul_a;
				end
				default: begin
					mul_a = $signed({3'b000, mz_q[vna_pkg::NORM_W-1:0]});
					mul_b = mul_a;
				end
			endcase
		end
	end

	// Root trial value and divider start value
	always_comb begin
		root_try = root_q + bit_q;
		case (cs_q)
			2'd0:    div_mag = mx_q[vna_pkg::NORM_W-1:0];
			2'd1:    div_mag = my_q[vna_pkg::NORM_W-1:0];
			default: div_mag = mz_q[vna_pkg::NORM_W-1:0];
		endcase
		div_num = vna_pkg::DIV_W'({div_mag, 14'd0}) + vna_pkg::DIV_W'(root_q[31:1]);
	end

	// Sequencer: next state and RAM controls
	always_comb begin
		state_d   = state_q;
		pos_we    = 1'b0;
		pos_raddr = to_addr(corner_rd);
		sum_we    = 1'b0;
		sum_waddr = to_addr(corner_acc);
		sum_wdata = sum_acc;
		sum_raddr = to_addr(corner_acc);
		case (state_q)
			vna_pkg::S_IDLE: begin
				if (req_take) begin
					case (req_data.req_type)
						vna_pkg::REQ_WRITE:    state_d = vna_pkg::S_POS_WR;
						vna_pkg::REQ_TRIANGLE: state_d = vna_pkg::S_TRI_RD;
						vna_pkg::REQ_READ:     state_d = vna_pkg::S_SUM_RD;
						default:               state_d = vna_pkg::S_IDLE;
					endcase
				end
			end
			vna_pkg::S_POS_WR: begin
				pos_we    = a_ok;
				sum_we    = a_ok;
				sum_waddr = to_addr(req_q.corner_a);
				sum_wdata = '0;
				state_d   = vna_pkg::S_IDLE;
			end
			vna_pkg::S_TRI_RD: begin
				if (!tri_ok) begin
					state_d = vna_pkg::S_IDLE;
				end else if (cnt_q == 6'd3) begin
					state_d = vna_pkg::S_EDGE;
				end
			end
			vna_pkg::S_EDGE:  state_d = vna_pkg::S_CROSS;
			vna_pkg::S_CROSS: begin
				if (cnt_q == 6'd6) begin
					state_d = vna_pkg::S_ACC_RD;
				end
			end
			vna_pkg::S_ACC_RD: state_d = vna_pkg::S_ACC_WR;
			vna_pkg::S_ACC_WR: begin
				sum_we  = 1'b1;
				state_d = (cs_q == 2'd2) ? vna_pkg::S_IDLE : vna_pkg::S_ACC_RD;
			end
			vna_pkg::S_SUM_RD: begin
				sum_raddr = to_addr(req_q.corner_a);
				state_d   = a_ok ? vna_pkg::S_SUM_LD : vna_pkg::S_DONE;
			end
			vna_pkg::S_SUM_LD: state_d = sums_zero ? vna_pkg::S_DONE : vna_pkg::S_NORM;
			vna_pkg::S_NORM: begin
				if (norm_ok) begin
					state_d = vna_pkg::S_SQ;
				end
			end
			vna_pkg::S_SQ: begin
				if (cnt_q == 6'd3) begin
					state_d = vna_pkg::S_ROOT;
				end
			end
			vna_pkg::S_ROOT: begin
				if (cnt_q != 6'd0 && bit_q == 64'd1) begin
					state_d = vna_pkg::S_DIV;
				end
			end
			vna_pkg::S_DIV: begin
				if (cnt_q == 6'd15 && cs_q == 2'd2) begin
					state_d = vna_pkg::S_DONE;
				end
			end
			vna_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = vna_pkg::S_IDLE;
				end
			end
			default: state_d = vna_pkg::S_IDLE;
		endcase
	end

	// State, step counter and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vna_pkg::S_IDLE;
			cnt_q       <= '0;
			cs_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == vna_pkg::S_DIV && cnt_q == 6'd15) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (state_q == vna_pkg::S_EDGE || state_q == vna_pkg::S_ROOT) begin
				cs_q <= '0;
			end else if (state_q == vna_pkg::S_ACC_WR) begin
				cs_q <= cs_q + 2'd1;
			end else if (state_q == vna_pkg::S_DIV && cnt_q == 6'd15) begin
				cs_q <= cs_q + 2'd1;
			end
			if (state_q == vna_pkg::S_DONE && state_d == vna_pkg::S_IDLE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (req_take) begin
			req_q <= req_data;
		end
		case (state_q)
			vna_pkg::S_TRI_RD: begin
				if (cnt_q != 6'd0) begin
					p_q[cnt_q[1:0] - 2'd1] <= pos_rdata;
				end
			end
			vna_pkg::S_EDGE: begin
				e1x_q <= vna_pkg::EDGE_W'($signed(p_q[1][15:0]))  - vna_pkg::EDGE_W'($signed(p_q[0][15:0]));
				e1y_q <= vna_pkg::EDGE_W'($signed(p_q[1][31:16])) - vna_pkg::EDGE_W'($signed(p_q[0][31:16]));
				e1z_q <= vna_pkg::EDGE_W'($signed(p_q[1][47:32])) - vna_pkg::EDGE_W'($signed(p_q[0][47:32]));
				e2x_q <= vna_pkg::EDGE_W'($signed(p_q[2][15:0]))  - vna_pkg::EDGE_W'($signed(p_q[0][15:0]));
				e2y_q <= vna_pkg::EDGE_W'($signed(p_q[2][31:16])) - vna_pkg::EDGE_W'($signed(p_q[0][31:16]));
				e2z_q <= vna_pkg::EDGE_W'($signed(p_q[2][47:32])) - vna_pkg::EDGE_W'($signed(p_q[0][47:32]));
			end
			vna_pkg::S_CROSS: begin
				case (cnt_q)
					6'd1: nx_q <= prod_q[vna_pkg::FACE_W-1:0];
					6'd2: nx_q <= nx_q - prod_q[vna_pkg::FACE_W-1:0];
					6'd3: ny_q <= prod_q[vna_pkg::FACE_W-1:0];
					6'd4: ny_q <= ny_q - prod_q[vna_pkg::FACE_W-1:0];
					6'd5: nz_q <= prod_q[vna_pkg::FACE_W-1:0];
					6'd6: nz_q <= nz_q - prod_q[vna_pkg::FACE_W-1:0];
					default: ;
				endcase
			end
			vna_pkg::S_SUM_RD: begin
				deg_q <= 1'b1;
			end
			vna_pkg::S_SUM_LD: begin
				deg_q  <= sums_zero;
				mx_q   <= mag_of(sum_rdata[0 +: SW]);
				my_q   <= mag_of(sum_rdata[SW +: SW]);
				mz_q   <= mag_of(sum_rdata[2*SW +: SW]);
				negx_q <= sum_rdata[SW-1];
				negy_q <= sum_rdata[2*SW-1];
				negz_q <= sum_rdata[3*SW-1];
			end
			vna_pkg::S_NORM: begin
				// Move the largest magnitude into the window one bit a cycle
				if (m_max >= (SW'(1) << 30)) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
					mz_q <= mz_q >> 1;
				end else if (m_max < (SW'(1) << 29)) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
					mz_q <= mz_q << 1;
				end
			end
			vna_pkg::S_SQ: begin
				case (cnt_q)
					6'd1:    sumsq_q <= prod_q[63:0];
					6'd2:    sumsq_q <= sumsq_q + prod_q[63:0];
					6'd3:    sumsq_q <= sumsq_q + prod_q[63:0];
					default: ;
				endcase
			end
			vna_pkg::S_ROOT: begin
				// Bit-serial integer square root, two bits of radicand a step
				if (cnt_q == 6'd0) begin
					rem_q  <= sumsq_q;
					root_q <= '0;
					bit_q  <= 64'd1 << 62;
				end else begin
					if (rem_q >= root_try) begin
						rem_q  <= rem_q - root_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			vna_pkg::S_DIV: begin
				// Restoring division, one quotient bit a step
				if (cnt_q == 6'd0) begin
					drem_q <= div_num;
					dd_q   <= vna_pkg::DIV_W'({root_q[31:0], 14'd0});
					quo_q  <= '0;
				end else begin
					if (drem_q >= dd_q) begin
						drem_q <= drem_q - dd_q;
					end
					quo_q <= {quo_q[vna_pkg::QUO_W-2:0], drem_q >= dd_q};
					dd_q  <= dd_q >> 1;
				end
				if (cnt_q == 6'd15) begin
					case (cs_q)
						2'd0:    qx_q <= {quo_q[vna_pkg::QUO_W-2:0], drem_q >= dd_q};
						2'd1:    qy_q <= {quo_q[vna_pkg::QUO_W-2:0], drem_q >= dd_q};
						default: qz_q <= {quo_q[vna_pkg::QUO_W-2:0], drem_q >= dd_q};
					endcase
				end
			end
			vna_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.vertex_index <= req_q.corner_a;
					rsp_q.degenerate   <= deg_q;
					if (deg_q) begin
						rsp_q.normal_x <= '0;
						rsp_q.normal_y <= '0;
						rsp_q.normal_z <= '0;
					end else begin
						rsp_q.normal_x <= negx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
						rsp_q.normal_y <= negy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
						rsp_q.normal_z <= negz_q ? -$signed({1'b0, qz_q}) : $signed({1'b0, qz_q});
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Checks
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.degenerate |->
		rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
		else $error("degenerate response with non-zero normal");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == vna_pkg::S_DONE)
		else $error("response raised outside the final state");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vna_pkg::S_DIV |-> root_q != '0)
		else $error("division by zero root");

	a_norm_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vna_pkg::S_SQ |-> m_max < (SW'(1) << 30) && m_max >= (SW'(1) << 29))
		else $error("magnitudes outside normalised window");

endmodule

// ===== design/vna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vna_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
